// File: rtl/csf_pkg.sv
package csf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH = 8;
	localparam int MAX_RELEASE = 16;
	localparam int PERMIT_W = 16;
	localparam int REL_FIELD_W = 5;
	localparam int STATUS_W = 3;

	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int UNITS_W = $clog2(MAX_RELEASE + 1);

	localparam int S_TDATA_W = ((ID_WIDTH + 1 + REL_FIELD_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((ID_WIDTH + PERMIT_W + 7) / 8) * 8;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef enum logic [0:0] {
		CFG_MAX_PERMITS     = 1'b0,
		CFG_INITIAL_PERMITS = 1'b1
	} cfg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 3'd0,
		ST_REFUSED = 3'd1,
		ST_QUEUED  = 3'd2,
		ST_FULL    = 3'd3,
		ST_WOKEN   = 3'd4,
		ST_DONE    = 3'd5
	} status_t;

	typedef struct packed {
		logic                is_signal;
		logic [ID_WIDTH-1:0] id;
		logic                no_wait;
		logic [UNITS_W-1:0]  units;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [ID_WIDTH-1:0] woken_id;
		logic [PERMIT_W-1:0] permits_now;
		logic                last;
	} res_t;

	typedef struct packed {
		logic [PERMIT_W-1:0] permits;
		logic [PERMIT_W-1:0] max_permits;
		logic [FILL_W-1:0]   fill;
	} stat_t;

	function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] ptr);
		return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

endpackage

// File: rtl/counting_semaphore_fifo_unit.sv
// Channel   Direction  Words carried
// s_axis    in         one request: wait (tuser 0) or signal release (tuser 1)
// m_axis    out        result words: one per wait, a run per signal ending with tlast high
// cfg       in         register write, no handshake, no read-back
//
// A wait passes through the input stage, the command queue and the execute stage
// before its result word is offered.
// A signal of N units (N clipped to 16) is worked off unit by unit in the release loop
// of the execute stage; a wake stalls while the output word is not taken.
// A two-entry command queue sits between the input stage and the execute stage.
// Reset leaves one permit, a maximum of one and an empty wait queue.
module counting_semaphore_fifo_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// requester_id, no_wait, release_units, zero fill
	input  logic [csf_pkg::S_TDATA_W-1:0] s_tdata,
	// kind
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// woken_id, permits_now
	output logic [csf_pkg::M_TDATA_W-1:0] m_tdata,
	// status
	output logic [csf_pkg::STATUS_W-1:0]  m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [csf_pkg::PERMIT_W-1:0]  cfg_wdata
);
	import csf_pkg::*;

	logic push_valid, push_ready, cmd_valid, cmd_pop;
	cmd_t push_cmd, cmd;
	res_t res;
	stat_t stat;

	csf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser[0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	csf_cmd_fifo u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_cmd    (cmd)
	);

	csf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.stat      (stat)
	);

	assign m_tdata = M_TDATA_W'({res.permits_now, res.woken_id});
	assign m_tuser = res.status;
	assign m_tlast = res.last;

`ifndef ASSERT_OFF
	a_count_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		stat.permits <= stat.max_permits)
		else $error("permit count above maximum");

	a_fill_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= FILL_W'(QUEUE_DEPTH))
		else $error("wait queue overfilled");

	a_last_marks_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != ST_WOKEN)))
		else $error("tlast does not match result status");

	a_woken_needs_waiter: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tuser == ST_WOKEN) |-> $past(stat.fill) != '0 ||
		$past(m_tvalid && !m_tready))
		else $error("wake issued with empty wait queue");
`endif

endmodule

// File: rtl/csf_front.sv
module csf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [csf_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	output logic                           push_valid,
	input  logic                           push_ready,
	output csf_pkg::cmd_t                  push_cmd
);
	import csf_pkg::*;

	logic v_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic [REL_FIELD_W-1:0] rel;

	// Release counts above the limit are clipped here so the back end never sees them.
	always_comb begin
		rel = s_tdata[ID_WIDTH+1 +: REL_FIELD_W];
		cmd_d.is_signal = s_tuser;
		cmd_d.id = s_tdata[ID_WIDTH-1:0];
		cmd_d.no_wait = s_tdata[ID_WIDTH];
		cmd_d.units = (int'(rel) > MAX_RELEASE) ? UNITS_W'(MAX_RELEASE) : UNITS_W'(rel);
	end

	assign s_tready = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: rtl/csf_cmd_fifo.sv
module csf_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  csf_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output csf_pkg::cmd_t pop_cmd
);
	import csf_pkg::*;

	cmd_t mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/csf_back.sv
module csf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [csf_pkg::PERMIT_W-1:0]  cfg_wdata,
	input  logic                          cmd_valid,
	output logic                          cmd_pop,
	input  csf_pkg::cmd_t                 cmd,
	output logic                          out_valid,
	input  logic                          out_ready,
	output csf_pkg::res_t                 out_res,
	output csf_pkg::stat_t                stat
);
	import csf_pkg::*;

	typedef enum logic [0:0] {
		S_IDLE,
		S_SIGNAL
	} state_t;

	state_t state_q, state_d;
	logic [PERMIT_W-1:0] max_q, init_q, count_q, count_d;
	logic [PERMIT_W-1:0] max_new, init_new;
	logic [QPTR_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [UNITS_W-1:0] units_q, units_d;
	logic [ID_WIDTH-1:0] wq_q [QUEUE_DEPTH];
	logic out_valid_q;
	res_t out_q, res_d;
	logic out_free, load, enq;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;
		units_d = units_q;
		cmd_pop = 1'b0;
		load = 1'b0;
		enq = 1'b0;
		res_d = '{status: ST_DONE, woken_id: '0, permits_now: count_q, last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_signal) begin
						cmd_pop = 1'b1;
						units_d = cmd.units;
						state_d = S_SIGNAL;
					end else if (out_free) begin
						cmd_pop = 1'b1;
						load = 1'b1;
						if (count_q != '0) begin
							count_d = count_q - 1'b1;
							res_d.status = ST_GRANTED;
						end else if (cmd.no_wait) begin
							res_d.status = ST_REFUSED;
						end else if (fill_q < FILL_W'(QUEUE_DEPTH)) begin
							enq = 1'b1;
							tail_d = next_slot(tail_q);
							fill_d = fill_q + 1'b1;
							res_d.status = ST_QUEUED;
						end else begin
							res_d.status = ST_FULL;
						end
						res_d.permits_now = count_d;
					end
				end
			end
			S_SIGNAL: begin
				if (units_q == '0) begin
					if (out_free) begin
						load = 1'b1;
						state_d = S_IDLE;
					end
				end else if (fill_q != '0) begin
					// Each released unit goes to the oldest waiter first.
					if (out_free) begin
						load = 1'b1;
						res_d.status = ST_WOKEN;
						res_d.woken_id = wq_q[head_q];
						res_d.last = 1'b0;
						head_d = next_slot(head_q);
						fill_d = fill_q - 1'b1;
						units_d = units_q - 1'b1;
					end
				end else begin
					if (count_q < max_q) begin
						count_d = count_q + 1'b1;
					end
					units_d = units_q - 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		max_new = max_q;
		init_new = init_q;
		case (cfg_index_t'(cfg_index))
			CFG_MAX_PERMITS: max_new = cfg_wdata;
			CFG_INITIAL_PERMITS: init_new = cfg_wdata;
			default: max_new = max_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_q <= PERMIT_W'(1);
			init_q <= PERMIT_W'(1);
			count_q <= PERMIT_W'(1);
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			units_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			units_q <= units_d;
			if (cfg_we) begin
				// A write reloads the count and drops every waiter.
				max_q <= max_new;
				init_q <= init_new;
				count_q <= (init_new <= max_new) ? init_new : max_new;
				head_q <= '0;
				tail_q <= '0;
				fill_q <= '0;
			end else begin
				count_q <= count_d;
				head_q <= head_d;
				tail_q <= tail_d;
				fill_q <= fill_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_d;
		end
		if (enq) begin
			wq_q[tail_q] <= cmd.id;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = out_q;
	assign stat = '{permits: count_q, max_permits: max_q, fill: fill_q};

endmodule

// File: tb/sv/tb_counting_semaphore_fifo_unit.sv
module tb_counting_semaphore_fifo_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import csf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic                   is_signal;
		logic [ID_WIDTH-1:0]    id;
		logic                   no_wait;
		logic [REL_FIELD_W-1:0] units;
	} sem_req_t;

	typedef struct packed {
		status_t             status;
		logic [ID_WIDTH-1:0] woken_id;
		logic [PERMIT_W-1:0] permits;
		logic                last;
	} sem_res_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic [0:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [STATUS_W-1:0]    m_tuser;
	logic                   m_tlast;
	logic                   cfg_we    = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [PERMIT_W-1:0]    cfg_wdata = '0;

	counting_semaphore_fifo_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Shadow semaphore state.
	logic [PERMIT_W-1:0] max_permits_q  = 16'd1;
	logic [PERMIT_W-1:0] init_permits_q = 16'd1;
	logic [PERMIT_W-1:0] permit_count   = 16'd1;
	logic [ID_WIDTH-1:0] waiter_ids[$];

	sem_req_t req_backlog[$];
	sem_res_t results_due[$];
	sem_req_t req_on_bus;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	bit hold_req      = 1'b0;
	int fail_count    = 0;

	function automatic sem_res_t mk_result(status_t st, logic [ID_WIDTH-1:0] id,
		logic [PERMIT_W-1:0] permits, logic last);
		sem_res_t r;
		r.status   = st;
		r.woken_id = id;
		r.permits  = permits;
		r.last     = last;
		return r;
	endfunction

	task automatic apply_request(input sem_req_t req);
		int n;
		if (!req.is_signal) begin
			if (permit_count > 0) begin
				permit_count = permit_count - 1'b1;
				results_due.push_back(mk_result(ST_GRANTED, '0, permit_count, 1'b1));
			end else if (req.no_wait) begin
				results_due.push_back(mk_result(ST_REFUSED, '0, permit_count, 1'b1));
			end else if (waiter_ids.size() < QUEUE_DEPTH) begin
				waiter_ids.push_back(req.id);
				results_due.push_back(mk_result(ST_QUEUED, '0, permit_count, 1'b1));
			end else begin
				results_due.push_back(mk_result(ST_FULL, '0, permit_count, 1'b1));
			end
		end else begin
			n = (req.units > MAX_RELEASE) ? MAX_RELEASE : int'(req.units);
			for (int i = 0; i < n; i++) begin
				if (waiter_ids.size() > 0) begin
					results_due.push_back(mk_result(ST_WOKEN, waiter_ids.pop_front(),
						permit_count, 1'b0));
				end else if (permit_count < max_permits_q) begin
					permit_count = permit_count + 1'b1;
				end
			end
			results_due.push_back(mk_result(ST_DONE, '0, permit_count, 1'b1));
		end
	endtask

	// Driver: a word stays on the bus until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				apply_request(req_on_bus);
			if (!s_tvalid || s_tready) begin
				if (req_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					req_on_bus <= req_backlog[0];
					s_tdata    <= {2'b00, req_backlog[0].units, req_backlog[0].no_wait,
						req_backlog[0].id};
					s_tuser    <= req_backlog[0].is_signal;
					s_tvalid   <= 1'b1;
					void'(req_backlog.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver back-pressure.
	int hold_left  = 0;
	bit hold_taken = 1'b0;

	always @(posedge clk) begin
		sem_res_t got;
		sem_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = mk_result(status_t'(m_tuser), m_tdata[ID_WIDTH-1:0],
					m_tdata[ID_WIDTH +: PERMIT_W], m_tlast);
				if (results_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word: status %0d id %0d permits %0d last %0d",
						$time, got.status, got.woken_id, got.permits, got.last);
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
					end
					if (got.woken_id !== want.woken_id) begin
						fail_count++;
						$display("%0t: woken_id expected %0d actual %0d",
							$time, want.woken_id, got.woken_id);
					end
					if (got.permits !== want.permits) begin
						fail_count++;
						$display("%0t: permits_now expected %0d actual %0d",
							$time, want.permits, got.permits);
					end
					if (got.last !== want.last) begin
						fail_count++;
						$display("%0t: last expected %0d actual %0d",
							$time, want.last, got.last);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_left  <= HOLD_CYCLES;
				hold_taken <= 1'b1;
				m_tready   <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input cfg_index_t idx, input logic [PERMIT_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_PERMITS)
			max_permits_q = value;
		else
			init_permits_q = value;
		// Any write reloads the count and flushes the waiters.
		permit_count = (init_permits_q <= max_permits_q) ? init_permits_q : max_permits_q;
		waiter_ids.delete();
		@(negedge clk);
	endtask

	task automatic add_req(input logic kind, input logic [ID_WIDTH-1:0] id,
		input logic nw, input logic [REL_FIELD_W-1:0] units);
		sem_req_t r;
		r.is_signal = kind;
		r.id        = id;
		r.no_wait   = nw;
		r.units     = units;
		req_backlog.push_back(r);
	endtask

	task automatic wait_drained();
		while (req_backlog.size() > 0 || s_tvalid || results_due.size() > 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int n_items, input int wait_pct,
		input int src_pct, input int snk_pct);
		int sel;
		logic [REL_FIELD_W-1:0] units;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		for (int i = 0; i < n_items; i++) begin
			sel = $urandom_range(99);
			if (sel < 70)
				units = REL_FIELD_W'($urandom_range(3));
			else if (sel < 90)
				units = REL_FIELD_W'($urandom_range(16, 4));
			else
				units = REL_FIELD_W'($urandom_range(31, 17));
			add_req($urandom_range(99) >= wait_pct, ID_WIDTH'($urandom),
				$urandom_range(3) == 0, units);
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset setting of one permit with a maximum of one.
		add_req(1'b0, 8'h00, 1'b0, 5'd0);
		add_req(1'b0, 8'hFF, 1'b1, 5'd31);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			add_req(1'b0, (i == 0) ? 8'hFF : (i[0] ? 8'h55 : 8'hAA) ^ i[7:0], 1'b0, 5'd0);
		// Queue is full now.
		add_req(1'b0, 8'h7E, 1'b0, 5'd0);
		// Over-long release, clipped, wakes all sixteen waiters.
		add_req(1'b1, 8'h00, 1'b0, 5'd31);
		add_req(1'b1, 8'hFF, 1'b1, 5'd0);
		// Count reaches the maximum and the remaining units are dropped.
		add_req(1'b1, 8'h00, 1'b0, 5'd16);
		add_req(1'b0, 8'h12, 1'b1, 5'd0);
		add_req(1'b1, 8'h00, 1'b0, 5'd17);
		wait_drained();

		// Zero maximum: blocking waits queue while the wait queue has room.
		write_reg(CFG_MAX_PERMITS, 16'h0000);
		write_reg(CFG_INITIAL_PERMITS, 16'h0000);
		run_phase(80, 60, 0, 0);

		write_reg(CFG_MAX_PERMITS, 16'hFFFF);
		write_reg(CFG_INITIAL_PERMITS, 16'hFFFF);
		run_phase(60, 50, 81, 0);

		// Initial value above the maximum is clamped.
		write_reg(CFG_INITIAL_PERMITS, 16'd7);
		write_reg(CFG_MAX_PERMITS, 16'd3);
		run_phase(80, 55, 0, 81);

		write_reg(CFG_MAX_PERMITS, 16'd2);
		write_reg(CFG_INITIAL_PERMITS, 16'd0);
		hold_req = 1'b1;
		run_phase(80, 60, 25, 25);

		write_reg(CFG_MAX_PERMITS, 16'($urandom_range(8)));
		write_reg(CFG_INITIAL_PERMITS, 16'($urandom_range(12)));
		run_phase(80, 55, 0, 0);

		write_reg(CFG_MAX_PERMITS, 16'hFFFF);
		write_reg(CFG_INITIAL_PERMITS, 16'h0000);
		run_phase(80, 45, 25, 25);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/csf_pkg.sv
rtl/csf_front.sv
rtl/csf_cmd_fifo.sv
rtl/csf_back.sv
rtl/counting_semaphore_fifo_unit.sv
tb/sv/tb_counting_semaphore_fifo_unit.sv
